@@ design/tcpm_pkg.sv @@
// shared types, constants and helpers for the tone curve pixel mapper
package tcpm_pkg;

    localparam int unsigned DEF_NUM_PIVOTS = 6;
    localparam int unsigned MAX_PIVOTS     = 8;
    localparam int unsigned REG_BYTES      = 6;
    localparam int unsigned REG_W          = 8 * REG_BYTES;
    localparam int unsigned APB_DATA_W     = 64;
    localparam int unsigned APB_ADDR_W     = 5;
    localparam int unsigned DIV_STEPS      = 8;
    localparam int unsigned NCH            = 2;
    localparam int unsigned CH_BLUE        = 0;
    localparam int unsigned CH_RED         = 1;

    localparam logic [1:0] REG_PIVOTS = 2'd0;
    localparam logic [1:0] REG_BLUE   = 2'd1;
    localparam logic [1:0] REG_RED    = 2'd2;

    localparam logic [REG_W-1:0] RST_PIVOTS = 48'hFFC8_9664_3200;
    localparam logic [REG_W-1:0] RST_BLUE   = 48'hFF96_4B28_1400;
    localparam logic [REG_W-1:0] RST_RED    = 48'hFFDC_BE96_5000;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } t_pix_out;

    // segment selection result per channel
    typedef struct packed {
        logic       direct;
        logic [7:0] y0;
        logic       neg;
        logic [7:0] dx;
        logic [7:0] dv;
        logic [7:0] dym;
    } t_sel;

    // divider lane state
    typedef struct packed {
        logic        direct;
        logic [7:0]  y0;
        logic        neg;
        logic [7:0]  dx;
        logic [15:0] rem;
        logic [7:0]  quo;
    } t_div;

    // byte k of a packed pivot register, zero past the last stored byte
    function automatic logic [7:0] byte_at(input logic [REG_W-1:0] r, input logic [3:0] k);
        logic [7:0] b;
        b = '0;
        for (int i = 0; i < int'(REG_BYTES); i++) begin
            if (k == 4'(i)) begin
                b = r[8*i +: 8];
            end
        end
        return b;
    endfunction

endpackage

@@ design/tone_curve_pixel_mapper_unit.sv @@
// tone curve pixel mapper: pipelined piecewise linear curves on blue and red
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+-------------------------------
//  pixel in  | i_pixel (blue, green, red)          | start high, busy low
//  pixel out | o_pixel (blue, green, red)          | o_done strobe, one cycle
//  config    | psel penable pwrite paddr pwdata    | apb read/write, pready always high
//
//  one pixel per clock
//  the divider is an 8-stage restoring divider, one quotient bit per stage
//  busy is always low, the pipeline never stalls and the receiver cannot stall
//  synchronous active-low reset clears valid bits and loads the default curves
module tone_curve_pixel_mapper_unit #(
    parameter int unsigned NUM_PIVOTS = tcpm_pkg::DEF_NUM_PIVOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  tcpm_pkg::t_pix_in                   i_pixel,
    output logic                                o_done,
    output tcpm_pkg::t_pix_out                  o_pixel,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tcpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tcpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tcpm_pkg::*;

    localparam int unsigned JW  = $clog2(NUM_PIVOTS + 1);
    localparam int unsigned LAT = 4 + DIV_STEPS;

    logic [REG_W-1:0] r_piv;
    logic [REG_W-1:0] r_blue;
    logic [REG_W-1:0] r_red;
    logic [REG_W-1:0] w_ys [NCH];
    logic [1:0]       w_idx;
    logic             w_wr;
    logic             w_acc;

    logic [LAT-1:0]   r_vld;
    logic [7:0]       r_grn [LAT-1];
    logic [7:0]       w_v   [NCH];
    logic [JW-1:0]    n_j   [NCH];
    logic [7:0]       r_v1  [NCH];
    logic [JW-1:0]    r_j1  [NCH];
    t_sel             n_sel [NCH];
    t_sel             r_sel [NCH];
    t_div             r_div [DIV_STEPS+1][NCH];
    t_div             n_div [1:DIV_STEPS][NCH];
    logic [7:0]       n_res [NCH];
    t_pix_out         r_out;

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:3];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piv  <= RST_PIVOTS;
            r_blue <= RST_BLUE;
            r_red  <= RST_RED;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PIVOTS: r_piv  <= pwdata[REG_W-1:0];
                REG_BLUE:   r_blue <= pwdata[REG_W-1:0];
                REG_RED:    r_red  <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PIVOTS: prdata = APB_DATA_W'(r_piv);
            REG_BLUE:   prdata = APB_DATA_W'(r_blue);
            REG_RED:    prdata = APB_DATA_W'(r_red);
            default:    prdata = '0;
        endcase
    end

    assign w_ys[CH_BLUE] = r_blue;
    assign w_ys[CH_RED]  = r_red;

    // request side
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;
    assign w_v[CH_BLUE] = i_pixel.blue_in;
    assign w_v[CH_RED]  = i_pixel.red_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_grn[0] <= i_pixel.green_in;
        for (int s = 1; s < int'(LAT) - 1; s++) begin
            r_grn[s] <= r_grn[s-1];
        end
    end

    // stage 1: first pivot at or above the value
    always_comb begin
        for (int c = 0; c < int'(NCH); c++) begin
            logic found;
            found  = 1'b0;
            n_j[c] = JW'(NUM_PIVOTS);
            for (int k = 0; k < int'(NUM_PIVOTS); k++) begin
                if (!found && !(w_v[c] > byte_at(r_piv, 4'(k)))) begin
                    found  = 1'b1;
                    n_j[c] = JW'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1 <= w_v;
        r_j1 <= n_j;
    end

    // stage 2: pick segment ends, catch exact pivots and the two outer ranges
    always_comb begin
        for (int c = 0; c < int'(NCH); c++) begin
            logic [3:0] j;
            logic [3:0] jm;
            logic [7:0] x0;
            logic [7:0] x1;
            logic [7:0] y0;
            logic [7:0] y1;
            j  = 4'(r_j1[c]);
            jm = (j == 4'd0) ? 4'd0 : j - 4'd1;
            x0 = byte_at(r_piv, jm);
            x1 = byte_at(r_piv, j);
            y0 = byte_at(w_ys[c], jm);
            y1 = byte_at(w_ys[c], j);
            n_sel[c].direct = 1'b1;
            n_sel[c].y0     = y0;
            if (j == 4'(NUM_PIVOTS)) begin
                n_sel[c].y0 = byte_at(w_ys[c], 4'(NUM_PIVOTS - 1));
            end else if (r_v1[c] == x1) begin
                n_sel[c].y0 = y1;
            end else if (j == 4'd0) begin
                n_sel[c].y0 = byte_at(w_ys[c], 4'd0);
            end else begin
                n_sel[c].direct = 1'b0;
            end
            n_sel[c].dx  = x1 - x0;
            n_sel[c].dv  = r_v1[c] - x0;
            n_sel[c].neg = (y1 < y0);
            n_sel[c].dym = (y1 < y0) ? (y0 - y1) : (y1 - y0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
    end

    // stage 3: product magnitude |dy| * (v - x0)
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < int'(NCH); c++) begin
            r_div[0][c].direct <= r_sel[c].direct;
            r_div[0][c].y0     <= r_sel[c].y0;
            r_div[0][c].neg    <= r_sel[c].neg;
            r_div[0][c].dx     <= r_sel[c].dx;
            r_div[0][c].rem    <= 16'(r_sel[c].dym) * 16'(r_sel[c].dv);
            r_div[0][c].quo    <= '0;
        end
    end

    // divider: one quotient bit per stage, msb first
    always_comb begin
        for (int k = 0; k < int'(DIV_STEPS); k++) begin
            for (int c = 0; c < int'(NCH); c++) begin
                logic [15:0] dd;
                dd = 16'(r_div[k][c].dx) << (int'(DIV_STEPS) - 1 - k);
                n_div[k+1][c] = r_div[k][c];
                if (r_div[k][c].rem >= dd) begin
                    n_div[k+1][c].rem = r_div[k][c].rem - dd;
                    n_div[k+1][c].quo[int'(DIV_STEPS) - 1 - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= int'(DIV_STEPS); k++) begin
            r_div[k] <= n_div[k];
        end
    end

    // falling segment rounds the quotient magnitude up for a floor toward minus infinity
    always_comb begin
        for (int c = 0; c < int'(NCH); c++) begin
            logic [8:0] qa;
            qa = {1'b0, r_div[DIV_STEPS][c].quo} + 9'(r_div[DIV_STEPS][c].rem != 16'd0);
            if (r_div[DIV_STEPS][c].direct) begin
                n_res[c] = r_div[DIV_STEPS][c].y0;
            end else if (r_div[DIV_STEPS][c].neg) begin
                n_res[c] = r_div[DIV_STEPS][c].y0 - qa[7:0];
            end else begin
                n_res[c] = r_div[DIV_STEPS][c].y0 + r_div[DIV_STEPS][c].quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.blue_out  <= n_res[CH_BLUE];
        r_out.green_out <= r_grn[LAT-2];
        r_out.red_out   <= n_res[CH_RED];
    end

    assign o_done  = r_vld[LAT-1];
    assign o_pixel = r_out;

    // every strobe traces back to an earlier request on start
    a_done_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && i_rst_n, LAT))
        else $error("result strobe without matching request");

    a_green_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pixel.green_out == $past(i_pixel.green_in, LAT)))
        else $error("green channel not passed through");

    a_blue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && !r_div[DIV_STEPS][CH_BLUE].direct)
            |-> (r_div[DIV_STEPS][CH_BLUE].rem < 16'(r_div[DIV_STEPS][CH_BLUE].dx)))
        else $error("blue divider remainder not below divisor");

    a_red_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && !r_div[DIV_STEPS][CH_RED].direct)
            |-> (r_div[DIV_STEPS][CH_RED].rem < 16'(r_div[DIV_STEPS][CH_RED].dx)))
        else $error("red divider remainder not below divisor");

endmodule
